>>> hdl/fsmr_pkg.sv
`timescale 1ns / 1ps

package fsmr_pkg;

    localparam int STATE_BITS    = 3;
    localparam int STATE_CNT_BITS = 4;
    localparam int PRED_COUNT    = 4;
    localparam int COL_BITS      = 2;
    localparam int ACTION_BITS   = 4;
    localparam int PERIOD_BITS   = 16;
    localparam int ERR_BITS      = 2;
    localparam int MAX_STATES    = 8;
    localparam int TRANS_BITS    = 48;
    localparam int TABLE_BITS    = 2 * TRANS_BITS;
    localparam int ACT_TAB_BITS  = MAX_STATES * ACTION_BITS;
    localparam int TAB_OFF_BITS  = 7;
    localparam int ACT_OFF_BITS  = 5;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 64;
    localparam int QUEUE_DEPTH   = 2;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_STATE_COUNT = 2'd0;
    localparam logic [1:0] REG_TRANS_LOW   = 2'd1;
    localparam logic [1:0] REG_TRANS_HIGH  = 2'd2;
    localparam logic [1:0] REG_ACTIONS     = 2'd3;

    // Error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_NO_BIT = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_MULTI  = 2'd2;
    localparam logic [ERR_BITS-1:0] ERR_RANGE  = 2'd3;

    typedef struct packed {
        logic [STATE_CNT_BITS-1:0] state_count;
        logic [TABLE_BITS-1:0]     transitions;
        logic [ACT_TAB_BITS-1:0]   actions;
    } fsmr_cfg_t;

    // Classified observation passed from front to back
    typedef struct packed {
        logic                restart;
        logic [ERR_BITS-1:0] err;
        logic [COL_BITS-1:0] col;
    } fsmr_item_t;

endpackage

>>> hdl/table_driven_fsm_runner.sv
`timescale 1ns / 1ps

// Table-driven Moore machine runner. Each observation (a one-hot predictor row
// and a period number) steps a configured machine of up to eight states and
// yields one result: the action of the state reached, that state, and an
// error code (no bit set, several bits set, next state not below state_count;
// on error the state holds and the action is 0). Period 0 or 1 restarts the
// machine in state 0. A new transaction can be taken every clock cycle while
// s_ready is high. An accepted observation is written into the two-entry queue
// between the classifying front end and the back end, which holds the state,
// does the table lookup and loads the output register. So each result passes
// through a queue entry and then the output register before m_valid rises.
// While a result waits on m_ready the back end holds, and the queue absorbs up
// to two more transactions before s_ready drops.
// Program the tables over the APB port (registers at byte offsets 0, 8, 16,
// 24) only while no transaction is in flight.
module table_driven_fsm_runner
    import fsmr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // APB configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,

    // Observation channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PRED_COUNT-1:0]    s_predictor_bits,
    input  logic [PERIOD_BITS-1:0]   s_period,

    // Result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ACTION_BITS-1:0]   m_decision,
    output logic [STATE_BITS-1:0]    m_new_state,
    output logic [ERR_BITS-1:0]      m_error_code
);

    fsmr_cfg_t  cfg;
    logic       fq_valid, fq_ready;
    fsmr_item_t fq_item;
    logic       qb_valid, qb_ready;
    fsmr_item_t qb_item;

    // Hold the machine description
    fsmr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classify each observation: restart, encode column, flag bad rows
    fsmr_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_predictor_bits (s_predictor_bits),
        .s_period         (s_period),
        .q_valid          (fq_valid),
        .q_ready          (fq_ready),
        .q_item           (fq_item)
    );

    // Decouple front and back so each side can stall on its own
    fsmr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Advance the machine and register the result transaction
    fsmr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (qb_valid),
        .in_ready     (qb_ready),
        .in_item      (qb_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_decision   (m_decision),
        .m_new_state  (m_new_state),
        .m_error_code (m_error_code)
    );

endmodule

>>> hdl/fsmr_cfg_regs.sv
`timescale 1ns / 1ps

module fsmr_cfg_regs
    import fsmr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output fsmr_cfg_t                cfg
);

    logic [STATE_CNT_BITS-1:0] state_count_reg;
    logic [TRANS_BITS-1:0]     trans_low_reg;
    logic [TRANS_BITS-1:0]     trans_high_reg;
    logic [ACT_TAB_BITS-1:0]   actions_reg;
    logic                      wr_en;
    logic [1:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg <= STATE_CNT_BITS'(1);
            trans_low_reg   <= '0;
            trans_high_reg  <= '0;
            actions_reg     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STATE_COUNT: state_count_reg <= pwdata[STATE_CNT_BITS-1:0];
                REG_TRANS_LOW:   trans_low_reg   <= pwdata[TRANS_BITS-1:0];
                REG_TRANS_HIGH:  trans_high_reg  <= pwdata[TRANS_BITS-1:0];
                REG_ACTIONS:     actions_reg     <= pwdata[ACT_TAB_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STATE_COUNT: prdata = CFG_DATA_BITS'(state_count_reg);
            REG_TRANS_LOW:   prdata = CFG_DATA_BITS'(trans_low_reg);
            REG_TRANS_HIGH:  prdata = CFG_DATA_BITS'(trans_high_reg);
            REG_ACTIONS:     prdata = CFG_DATA_BITS'(actions_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.state_count = state_count_reg;
    assign cfg.transitions = {trans_high_reg, trans_low_reg};
    assign cfg.actions     = actions_reg;

endmodule

>>> hdl/fsmr_front.sv
`timescale 1ns / 1ps

module fsmr_front
    import fsmr_pkg::*;
(
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PRED_COUNT-1:0]  s_predictor_bits,
    input  logic [PERIOD_BITS-1:0] s_period,
    output logic                   q_valid,
    input  logic                   q_ready,
    output fsmr_item_t             q_item
);

    logic [2:0]          ones;
    logic [COL_BITS-1:0] col;

    // Encode the one-hot row; highest set bit wins, count tells the error
    always_comb begin
        ones = '0;
        col  = '0;
        for (int k = 0; k < PRED_COUNT; k++) begin
            if (s_predictor_bits[k]) begin
                ones = ones + 3'd1;
                col  = COL_BITS'(k);
            end
        end
    end

    always_comb begin
        q_item.restart = (s_period[PERIOD_BITS-1:1] == '0);
        q_item.col     = col;
        priority if (q_item.restart) begin
            q_item.err = ERR_NONE;
        end else if (ones == 3'd0) begin
            q_item.err = ERR_NO_BIT;
        end else if (ones != 3'd1) begin
            q_item.err = ERR_MULTI;
        end else begin
            q_item.err = ERR_NONE;
        end
    end

    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

>>> hdl/fsmr_queue.sv
`timescale 1ns / 1ps

module fsmr_queue
    import fsmr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  fsmr_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output fsmr_item_t out_item
);

    fsmr_item_t entries_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hdl/fsmr_back.sv
`timescale 1ns / 1ps

module fsmr_back
    import fsmr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fsmr_cfg_t              cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fsmr_item_t             in_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ACTION_BITS-1:0] m_decision,
    output logic [STATE_BITS-1:0]  m_new_state,
    output logic [ERR_BITS-1:0]    m_error_code
);

    logic [STATE_BITS-1:0]   state_reg,    state_next;
    logic                    valid_reg,    valid_next;
    logic [ACTION_BITS-1:0]  decision_reg, decision_next;
    logic [ERR_BITS-1:0]     err_reg,      err_next;
    logic [STATE_BITS-1:0]   nxt;
    logic [TAB_OFF_BITS-1:0] tab_off;
    logic [STATE_BITS-1:0]   act_state;
    logic [ACT_OFF_BITS-1:0] act_off;
    logic                    pop;

    assign in_ready = !valid_reg || m_ready;
    assign pop      = in_valid && in_ready;

    // Entry for (state, column) sits at bit 3 * (4 * state + column)
    assign tab_off = TAB_OFF_BITS'({state_reg, in_item.col}) * TAB_OFF_BITS'(STATE_BITS);
    assign nxt     = cfg.transitions[tab_off +: STATE_BITS];

    assign act_state = in_item.restart ? '0 : nxt;
    assign act_off   = ACT_OFF_BITS'({act_state, 2'b00});

    always_comb begin
        state_next    = state_reg;
        decision_next = '0;
        err_next      = in_item.err;
        priority if (in_item.restart) begin
            state_next    = '0;
            decision_next = cfg.actions[act_off +: ACTION_BITS];
        end else if (in_item.err != ERR_NONE) begin
            decision_next = '0;
        end else if ({1'b0, nxt} >= cfg.state_count) begin
            err_next = ERR_RANGE;
        end else begin
            state_next    = nxt;
            decision_next = cfg.actions[act_off +: ACTION_BITS];
        end
    end

    assign valid_next = pop || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            decision_reg <= decision_next;
            err_reg      <= err_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_decision   = decision_reg;
    assign m_new_state  = state_reg;
    assign m_error_code = err_reg;

endmodule
